// ===== rtl/btr_pkg.sv =====
`timescale 1ns / 1ps

package btr_pkg;

    // Default sizes
    localparam int TAKES_DEF = 4;
    localparam int STEPS_DEF = 256;

    // Register reset values
    localparam logic [19:0] PERIOD_RST  = 20'd24000;
    localparam logic [19:0] CAP_LIM_RST = 20'd12000;

    // Register indexes
    localparam logic [0:0] CFG_PERIOD  = 1'b0;
    localparam logic [0:0] CFG_CAP_LIM = 1'b1;

    // Operation codes
    localparam logic [2:0] OP_RECORD     = 3'd0;
    localparam logic [2:0] OP_READ       = 3'd1;
    localparam logic [2:0] OP_CLR_LEN    = 3'd2;
    localparam logic [2:0] OP_CLR_ALL    = 3'd3;
    localparam logic [2:0] OP_CLR_QUEUED = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  transpose;
        logic        rec_mode;
        logic [19:0] clock_pos;
        logic [1:0]  read_take;
        logic [7:0]  read_index;
    } t_in_req;

    typedef struct packed {
        logic [7:0] read_value;
        logic [7:0] read_length;
        logic [1:0] take_count;
        logic       queued;
        logic       recording_active;
        logic [7:0] write_index;
    } t_out_req;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic wr2;
        logic load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_wr2;
        logic out_busy;
    } t_dp_status;

endpackage

// ===== rtl/beat_aligned_take_recorder_core.sv =====
`timescale 1ns / 1ps

// Take recorder: stores one transpose value per sequencer step into a ring
// of take buffers, with start/stop changes aligned to every fourth step.
// Input channel: i_in_valid / o_in_stall carrying i_in_req. Ops are record
// step, read entry, clear lengths, clear lengths and take count, clear the
// queued flag. Output channel: o_out_valid / i_out_stall carrying o_out_req,
// exactly one response per request, in order.
// Config: i_cfg_we / i_cfg_addr / i_cfg_wdata; index 0 is the period,
// index 1 the capture limit. Write only while no request is in flight.
// A request passes the states EXEC and LOAD after accept; a start step that
// captures the value twice adds WR2 between them, since the single store
// write port takes one write a cycle. One request is in flight at a time:
// the next is taken only after the previous result is loaded.
// A finished response waits in the output register; a new request is taken
// meanwhile, and its result is held back until the previous one is taken.
// Reset (synchronous, active low) clears lengths, take count, step index
// and flags, and restores the register defaults. The store itself is not
// cleared: entries never written read back undefined.
module beat_aligned_take_recorder_core #(
    parameter int TAKES = btr_pkg::TAKES_DEF,
    parameter int STEPS = btr_pkg::STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  btr_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output btr_pkg::t_out_req o_out_req,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_addr,
    input  logic [19:0]       i_cfg_wdata
);
    import btr_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    btr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    btr_datapath #(
        .TAKES (TAKES),
        .STEPS (STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_req    (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

endmodule

// ===== rtl/btr_ctrl.sv =====
`timescale 1ns / 1ps

module btr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  btr_pkg::t_dp_status i_status,
    output btr_pkg::t_dp_cmd   o_cmd,
    output logic               o_in_stall
);
    import btr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WR2,
        S_LOAD
    } t_state;

    t_state r_state;
    logic   r_stall;

    // State and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                        r_stall <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= i_status.need_wr2 ? S_WR2 : S_LOAD;
                end
                S_WR2: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (!i_status.out_busy) begin
                        r_state <= S_IDLE;
                        r_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_stall <= 1'b0;
                end
            endcase
        end
    end

    // Commands
    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.wr2    = (r_state == S_WR2);
        o_cmd.load   = (r_state == S_LOAD) && !i_status.out_busy;
    end

    assign o_in_stall = r_stall;

endmodule

// ===== rtl/btr_datapath.sv =====
`timescale 1ns / 1ps

module btr_datapath #(
    parameter int TAKES = btr_pkg::TAKES_DEF,
    parameter int STEPS = btr_pkg::STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btr_pkg::t_dp_cmd    i_cmd,
    output btr_pkg::t_dp_status o_status,
    input  btr_pkg::t_in_req    i_in_req,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_addr,
    input  logic [19:0]         i_cfg_wdata,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output btr_pkg::t_out_req   o_out_req
);
    import btr_pkg::*;

    localparam int CT_W  = (TAKES > 1) ? $clog2(TAKES) : 1;
    localparam int SI_W  = $clog2(STEPS);
    localparam int AD_W  = CT_W + SI_W;
    localparam int DEPTH = TAKES << SI_W;
    localparam logic [CT_W-1:0] CT_LAST = CT_W'(TAKES - 1);
    localparam logic [SI_W-1:0] SI_LAST = SI_W'(STEPS - 1);

    t_in_req         r_item;
    logic [19:0]     r_period;
    logic [19:0]     r_cap_lim;
    logic [SI_W-1:0] r_len [TAKES];
    logic [CT_W-1:0] r_ct;
    logic [SI_W-1:0] r_step;
    logic            r_active;
    logic            r_prev;
    logic            r_queued;
    logic            r_rd_ok;
    logic [7:0]      r_rd_data;
    logic            r_out_valid;
    t_out_req        r_out;

    logic [7:0]      mem [DEPTH];

    logic            is_rec;
    logic            late;
    logic            change;
    logic            start;
    logic            stop_ok;
    logic            cap;
    logic            n_active;
    logic            wr_exec;
    logic [SI_W-1:0] step_inc;
    logic [CT_W-1:0] ct_inc;
    logic            take_ok;
    logic            idx_ok;
    logic [CT_W-1:0] rd_take;
    logic [SI_W-1:0] rd_idx;
    logic            mem_we;

    // Step decisions for a record request
    always_comb begin
        is_rec   = (r_item.op == OP_RECORD);
        late     = r_prev && (r_step[1:0] == 2'd1) &&
                   ({r_item.clock_pos, 1'b0} < {1'b0, r_period});
        change   = (r_item.rec_mode != r_prev) && ((r_step[1:0] == 2'd0) || late);
        start    = is_rec && change && r_item.rec_mode;
        stop_ok  = is_rec && change && !r_item.rec_mode && r_active && (r_step != '0);
        cap      = (r_item.clock_pos < r_cap_lim);
        n_active = stop_ok ? 1'b0 : (start ? 1'b1 : r_active);
        wr_exec  = is_rec && n_active;
        step_inc = (r_step == SI_LAST) ? '0 : r_step + 1'b1;
        ct_inc   = (r_ct == CT_LAST) ? '0 : r_ct + 1'b1;
    end

    // Read-back address checks
    always_comb begin
        take_ok = (32'(r_item.read_take) < 32'(TAKES));
        idx_ok  = (32'(r_item.read_index) < 32'(STEPS));
        rd_take = CT_W'(r_item.read_take);
        rd_idx  = SI_W'(r_item.read_index);
    end

    assign mem_we = (i_cmd.exec && wr_exec) || i_cmd.wr2;

    // Take store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[{r_ct, r_step}] <= r_item.transpose;
        end
        if (i_cmd.exec && (r_item.op == OP_READ) && take_ok && idx_ok) begin
            r_rd_data <= mem[AD_W'({rd_take, rd_idx})];
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_req;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PERIOD_RST;
            r_cap_lim <= CAP_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PERIOD:  r_period  <= i_cfg_wdata;
                CFG_CAP_LIM: r_cap_lim <= i_cfg_wdata;
                default:     r_period  <= r_period;
            endcase
        end
    end

    // Recorder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAKES; i++) begin
                r_len[i] <= '0;
            end
            r_ct     <= '0;
            r_step   <= '0;
            r_active <= 1'b0;
            r_prev   <= 1'b0;
            r_queued <= 1'b0;
            r_rd_ok  <= 1'b0;
        end else if (i_cmd.exec) begin
            r_rd_ok <= (r_item.op == OP_READ) && take_ok && idx_ok;
            unique case (r_item.op)
                OP_RECORD: begin
                    if (change) begin
                        r_prev <= r_item.rec_mode;
                    end
                    r_active <= n_active;
                    if (stop_ok) begin
                        r_len[r_ct] <= r_step;
                        r_queued    <= 1'b1;
                        r_step      <= '0;
                        r_ct        <= ct_inc;
                    end else if (wr_exec) begin
                        r_step <= step_inc;
                    end
                end
                OP_CLR_LEN: begin
                    r_step <= '0;
                    for (int i = 0; i < TAKES; i++) begin
                        r_len[i] <= '0;
                    end
                end
                OP_CLR_ALL: begin
                    r_step <= '0;
                    r_ct   <= '0;
                    for (int i = 0; i < TAKES; i++) begin
                        r_len[i] <= '0;
                    end
                end
                OP_CLR_QUEUED: begin
                    r_queued <= 1'b0;
                end
                default: begin
                    r_queued <= r_queued;
                end
            endcase
        end else if (i_cmd.wr2) begin
            // second capture on a start step
            r_step <= step_inc;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.read_value       <= r_rd_ok ? r_rd_data : 8'd0;
            r_out.read_length      <= take_ok ? 8'(r_len[rd_take]) : 8'd0;
            r_out.take_count       <= 2'(r_ct);
            r_out.queued           <= r_queued;
            r_out.recording_active <= r_active;
            r_out.write_index      <= 8'(r_step);
        end
    end

    always_comb begin
        o_status.need_wr2 = start && cap;
        o_status.out_busy = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

// ===== rtl/btr_checker.sv =====
`timescale 1ns / 1ps

module btr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input btr_pkg::t_out_req o_out_req
);

    // One request at a time: accept closes the input side
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // A response only appears while a request is in flight
    a_resp_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("response without request");

    // Input side reopens only once the response is loaded
    a_reopen_with_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("input reopened without response");

    // A stalled response stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_req)))
        else $error("stalled response dropped or changed");

endmodule

bind beat_aligned_take_recorder_core btr_checker u_btr_checker (.*);

// ===== sim/take_recorder_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port of the take recorder. It keeps
// its own copy of the recorder state, works out the status word that each
// accepted request should produce, and compares the responses in order.
module take_recorder_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  btr_pkg::t_in_req  i_in_req,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  btr_pkg::t_out_req i_out_req,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_addr,
    input  logic [19:0]       i_cfg_wdata,
    output int                o_fail_count,
    output int                o_due_count,
    output logic [1023:0]     o_written
);

    import btr_pkg::*;

    // Shadow of the recorder
    logic [7:0]    take_mem [0:TAKES_DEF-1][0:STEPS_DEF-1];
    logic [1023:0] written_map = '0;
    logic [7:0]    take_len [0:TAKES_DEF-1];
    logic [1:0]    take_no;
    logic [7:0]    step_no;
    logic          active_f;
    logic          prev_mode;
    logic          queued_f;
    logic [19:0]   period_r;
    logic [19:0]   cap_lim_r;

    t_out_req due_status[$];
    int       fail_count = 0;
    int       due_count = 0;

    assign o_fail_count = fail_count;
    assign o_due_count  = due_count;
    assign o_written    = written_map;

    task automatic clear_recorder();
        for (int t = 0; t < TAKES_DEF; t++) take_len[t] = '0;
        take_no   = '0;
        step_no   = '0;
        active_f  = 1'b0;
        prev_mode = 1'b0;
        queued_f  = 1'b0;
        period_r  = PERIOD_RST;
        cap_lim_r = CAP_LIM_RST;
        written_map = '0;
    endtask

    // Write one value at the current step and move the step on (wraps)
    task automatic capture_value(input logic [7:0] value);
        take_mem[take_no][step_no] = value;
        written_map[{take_no, step_no}] = 1'b1;
        step_no = step_no + 8'd1;
    endtask

    // Mode changes land on every fourth step, or one step late on the way
    // out of a nonzero mode while in the first half of the period
    task automatic record_step(input logic [7:0] value, input logic mode,
                               input logic [19:0] pos);
        logic late;
        late = prev_mode && (step_no[1:0] == 2'd1) &&
               ({pos, 1'b0} < {1'b0, period_r});
        if (mode != prev_mode && (step_no[1:0] == 2'd0 || late)) begin
            if (!mode) begin
                // an empty take is not closed
                if (active_f && step_no != 8'd0) begin
                    take_len[take_no] = step_no;
                    queued_f = 1'b1;
                    active_f = 1'b0;
                    step_no  = '0;
                    take_no  = take_no + 2'd1;
                end
            end else begin
                active_f = 1'b1;
                if (pos < cap_lim_r) capture_value(value);
            end
            prev_mode = mode;
        end
        if (active_f) capture_value(value);
    endtask

    task automatic advance_recorder(input t_in_req r, output t_out_req res);
        logic [7:0] rval;
        rval = '0;
        case (r.op)
            OP_RECORD:     record_step(r.transpose, r.rec_mode, r.clock_pos);
            OP_READ:       rval = take_mem[r.read_take][r.read_index];
            OP_CLR_LEN: begin
                step_no = '0;
                for (int t = 0; t < TAKES_DEF; t++) take_len[t] = '0;
            end
            OP_CLR_ALL: begin
                step_no = '0;
                for (int t = 0; t < TAKES_DEF; t++) take_len[t] = '0;
                take_no = '0;
            end
            OP_CLR_QUEUED: queued_f = 1'b0;
            default: ;
        endcase
        res.read_value       = rval;
        res.read_length      = take_len[r.read_take];
        res.take_count       = take_no;
        res.queued           = queued_f;
        res.recording_active = active_f;
        res.write_index      = step_no;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Sample on the rising edge: registers, then responses, then requests
    always @(posedge i_clk) begin
        t_out_req want;
        t_out_req got;
        if (!i_rst_n) begin
            clear_recorder();
            due_status.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_PERIOD) period_r = i_cfg_wdata;
                else if (i_cfg_addr == CFG_CAP_LIM) cap_lim_r = i_cfg_wdata;
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_req;
                if (due_status.size() == 0) begin
                    fail_count++;
                    $display("%0t: response with none expected, got %h", $time, got);
                end else begin
                    want = due_status.pop_front();
                    compare_field("read_value", 32'(want.read_value),
                                  32'(got.read_value));
                    compare_field("read_length", 32'(want.read_length),
                                  32'(got.read_length));
                    compare_field("take_count", 32'(want.take_count),
                                  32'(got.take_count));
                    compare_field("queued", 32'(want.queued), 32'(got.queued));
                    compare_field("recording_active", 32'(want.recording_active),
                                  32'(got.recording_active));
                    compare_field("write_index", 32'(want.write_index),
                                  32'(got.write_index));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_recorder(i_in_req, want);
                due_status.push_back(want);
            end
        end
        due_count = due_status.size();
    end

endmodule

// ===== sim/beat_aligned_take_recorder_core_test.sv =====
`timescale 1ns / 1ps

// Drives the take recorder with a directed opening and then random take
// sequences under several register settings; the checker beside the block
// predicts and compares every response.
module beat_aligned_take_recorder_core_test;

    import btr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 285;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    t_in_req       in_req = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    t_out_req      out_req;
    logic          cfg_we = 1'b0;
    logic [0:0]    cfg_addr = CFG_PERIOD;
    logic [19:0]   cfg_wdata = '0;
    int            fail_count;
    int            due_count;
    logic [1023:0] written;

    logic          idle_on = 1'b1;
    logic [19:0]   cur_period = PERIOD_RST;
    logic [19:0]   cur_cap = CAP_LIM_RST;
    logic          mode_want = 1'b0;
    int            run_left = 0;
    int            stall_cycles = 0;

    beat_aligned_take_recorder_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    take_recorder_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_req    (out_req),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_due_count  (due_count),
        .o_written    (written)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side backpressure
    always @(negedge i_clk) begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 18);
    end

    // Watchdog: too long without any request or response moving
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("beat_aligned_take_recorder_core regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_in_req mk(input logic [2:0] op, input logic [7:0] tr,
                                   input logic mode, input logic [19:0] pos,
                                   input logic [1:0] tk, input logic [7:0] ix);
        t_in_req r;
        r.op         = op;
        r.transpose  = tr;
        r.rec_mode   = mode;
        r.clock_pos  = pos;
        r.read_take  = tk;
        r.read_index = ix;
        return r;
    endfunction

    // Positions cluster on the late-window and capture boundaries
    function automatic logic [19:0] pick_pos();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 20'hFFFFF;
            2:       return (cur_period >> 1) + 20'($urandom_range(0, 4)) - 20'd2;
            3:       return cur_cap + 20'($urandom_range(0, 4)) - 20'd2;
            default: return 20'($urandom);
        endcase
    endfunction

    // Read address among entries already written; scan from a random start
    task automatic pick_written(output logic ok, output logic [9:0] addr);
        logic [9:0] start;
        start = 10'($urandom);
        ok = 1'b0;
        addr = '0;
        for (int n = 0; n < 1024 && !ok; n++) begin
            if (written[10'(start + n)]) begin
                ok = 1'b1;
                addr = 10'(start + n);
            end
        end
    endtask

    task automatic make_request(output t_in_req r);
        int         pick;
        logic       ok;
        logic [9:0] addr;
        r = mk(3'($urandom), 8'($urandom), 1'($urandom), pick_pos(),
               2'($urandom), 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            // take runs: mostly short, now and then long enough to wrap
            if (run_left == 0) begin
                mode_want = !mode_want;
                run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 300)
                                                        : $urandom_range(1, 40);
            end
            run_left--;
            r.op = OP_RECORD;
            if ($urandom_range(0, 9) != 0) r.rec_mode = mode_want;
        end else if (pick < 85) begin
            pick_written(ok, addr);
            if (ok) begin
                r.op = OP_READ;
                {r.read_take, r.read_index} = addr;
            end else begin
                r.op = OP_CLR_QUEUED;
            end
        end else if (pick < 88) begin
            r.op = OP_CLR_LEN;
        end else if (pick < 90) begin
            r.op = OP_CLR_ALL;
        end else if (pick < 95) begin
            r.op = OP_CLR_QUEUED;
        end else begin
            r.op = 3'($urandom_range(5, 7));
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic push_request(input t_in_req r);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 18) begin
                in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_valid <= 1'b1;
        in_req <= r;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (due_count != 0) @(negedge i_clk);
    endtask

    // Both registers, written back to back while idle
    task automatic set_config(input logic [19:0] per, input logic [19:0] cap);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_PERIOD;
        cfg_wdata <= per;
        @(negedge i_clk);
        cfg_addr <= CFG_CAP_LIM;
        cfg_wdata <= cap;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cur_period = per;
        cur_cap = cap;
    endtask

    initial begin
        t_in_req     directed[$];
        t_in_req     r;
        logic [19:0] per;
        logic [19:0] cap;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_config(PERIOD_RST, CAP_LIM_RST);

        // Directed opening: unknown ops, idle stop, double capture on start,
        // aligned stop, read-back, late stop, clears, stop on an empty take
        directed.push_back(mk(OP_CLR_QUEUED, 8'h00, 1'b0, 20'd0, 2'd0, 8'd0));
        directed.push_back(mk(3'd5, 8'hFF, 1'b1, 20'hFFFFF, 2'd3, 8'hFF));
        directed.push_back(mk(3'd6, 8'h00, 1'b0, 20'd0, 2'd0, 8'h00));
        directed.push_back(mk(3'd7, 8'hA5, 1'b1, 20'h5A5A5, 2'd2, 8'h5A));
        directed.push_back(mk(OP_RECORD, 8'h12, 1'b0, 20'd0, 2'd0, 8'd0));
        directed.push_back(mk(OP_RECORD, 8'hFF, 1'b1, 20'd0, 2'd0, 8'd0));
        directed.push_back(mk(OP_RECORD, 8'h00, 1'b1, 20'hFFFFF, 2'd0, 8'd0));
        directed.push_back(mk(OP_RECORD, 8'h5A, 1'b1, 20'd11999, 2'd0, 8'd0));
        directed.push_back(mk(OP_RECORD, 8'h77, 1'b0, 20'd12000, 2'd0, 8'd0));
        for (int i = 0; i < 4; i++)
            directed.push_back(mk(OP_READ, 8'h00, 1'b0, 20'd0, 2'd0, 8'(i)));
        directed.push_back(mk(OP_CLR_QUEUED, 8'h00, 1'b0, 20'd0, 2'd0, 8'd0));
        directed.push_back(mk(OP_RECORD, 8'h11, 1'b1, 20'hFFFFF, 2'd1, 8'd0));
        directed.push_back(mk(OP_RECORD, 8'h22, 1'b0, 20'd11999, 2'd1, 8'd0));
        directed.push_back(mk(OP_RECORD, 8'h33, 1'b1, 20'd100, 2'd2, 8'd0));
        directed.push_back(mk(OP_RECORD, 8'h44, 1'b1, 20'd100, 2'd2, 8'd0));
        directed.push_back(mk(OP_CLR_LEN, 8'h00, 1'b0, 20'd0, 2'd1, 8'd0));
        directed.push_back(mk(OP_RECORD, 8'h55, 1'b0, 20'd0, 2'd2, 8'd0));
        directed.push_back(mk(OP_CLR_ALL, 8'h00, 1'b0, 20'd0, 2'd0, 8'd0));
        directed.push_back(mk(OP_READ, 8'h00, 1'b0, 20'd0, 2'd1, 8'd0));
        directed.push_back(mk(OP_READ, 8'h00, 1'b0, 20'd0, 2'd2, 8'd2));
        foreach (directed[i]) push_request(directed[i]);

        // Random phases, one register setting each
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0: begin per = 20'd1;       cap = 20'd0;       end
                1: begin per = 20'hFFFFF;   cap = 20'hFFFFF;   end
                3: begin per = 20'd2;       cap = 20'd1;       end
                5: begin per = PERIOD_RST;  cap = CAP_LIM_RST; end
                default: begin
                    per = 20'($urandom_range(1, 20'hFFFFF));
                    cap = 20'($urandom);
                end
            endcase
            set_config(per, cap);
            // one whole phase with no idling on either side
            idle_on = (ph != 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off until every response is in
                if (ph == 2 && n == PHASE_ITEMS / 2) wait_drained();
                make_request(r);
                push_request(r);
            end
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && due_count == 0) begin
            $display("beat_aligned_take_recorder_core regression: pass");
        end else begin
            $display("beat_aligned_take_recorder_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/btr_pkg.sv
rtl/btr_ctrl.sv
rtl/btr_datapath.sv
rtl/beat_aligned_take_recorder_core.sv
rtl/btr_checker.sv
sim/take_recorder_checker.sv
sim/beat_aligned_take_recorder_core_test.sv
